>>> rtl/permutation_count_mod_prime_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the permutation count block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_COUNT_MOD_PRIME_ASSERT_SVH
`define PERMUTATION_COUNT_MOD_PRIME_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCMP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcmp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcmp assertion failed");

`endif

>>> rtl/pcmp_pkg.sv
// ----------------------------------------------------------------------------
// pcmp_pkg
// Widths, reset values and the sequencer state type of the permutation count.
// ----------------------------------------------------------------------------
`default_nettype none

package pcmp_pkg;

  // Modulus and residue width.
  localparam int unsigned MOD_W = 30;
  // Width of the count fields.
  localparam int unsigned CNT_W = 16;
  // Width of the bit counter in the modular multiplier.
  localparam int unsigned STEP_W = $clog2(MOD_W);
  // Modulus after reset.
  localparam logic [MOD_W-1:0] MOD_RESET = 30'd1000000007;
  // Default saturation limit of the counts.
  localparam int unsigned MAX_COUNT_DEF = 65535;

  // Sequencer states: each multiply has an issue state and a wait state.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FACT_GO,
    ST_FACT_WAIT,
    ST_POW_BIT,
    ST_PMUL_GO,
    ST_PMUL_WAIT,
    ST_SQR_GO,
    ST_SQR_WAIT,
    ST_FIN_GO,
    ST_FIN_WAIT
  } pcmp_state_t;

endpackage

`default_nettype wire

>>> rtl/pcmp_modmul.sv
// ----------------------------------------------------------------------------
// pcmp_modmul
// Bit-serial modular multiplier: p = a * b mod m by double-and-add, one bit
// of b per cycle, most significant bit first.
// ----------------------------------------------------------------------------
`default_nettype none

module pcmp_modmul
  import pcmp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [MOD_W-1:0] a,
  input  wire logic [MOD_W-1:0] b,
  input  wire logic [MOD_W-1:0] m,
  output logic                  done,
  output logic      [MOD_W-1:0] p
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [MOD_W-1:0]  a_r, a_nxt;
  logic [MOD_W-1:0]  b_r, b_nxt;
  logic [MOD_W-1:0]  r_r, r_nxt;

  // Double the partial result, add a when the current bit is set, then bring
  // the sum (below three times m) back under m with one of two subtractions.
  logic [MOD_W+1:0] sum;
  logic [MOD_W+1:0] m1;
  logic [MOD_W+1:0] m2;
  logic [MOD_W+1:0] red;

  always_comb begin
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    sum = {1'b0, r_r, 1'b0} + (b_r[MOD_W-1] ? {2'b00, a_r} : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  // Step control and operand shift register.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(MOD_W - 1);
      a_nxt    = a;
      b_nxt    = b;
      r_nxt    = '0;
    end else if (busy_r) begin
      r_nxt    = red[MOD_W-1:0];
      b_nxt    = {b_r[MOD_W-2:0], 1'b0};
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    r_r    <= r_nxt;
  end

  assign done = done_r;
  assign p    = r_r;

endmodule

`default_nettype wire

>>> rtl/permutation_count_mod_prime.sv
// A modulus below two answers in the cycle after the request is taken.
// Every modular multiply runs in the shared bit-serial multiplier; one request is worked
//   at a time and busy is high meanwhile.
// Reset (synchronous, active low) returns to idle and loads the modulus 1000000007.
// ----------------------------------------------------------------------------
// permutation_count_mod_prime
// Ordered selections of n out of k modulo a prime: k! * ((k-n)!)^(m-2) mod m.
// ----------------------------------------------------------------------------
`default_nettype none

module permutation_count_mod_prime
  import pcmp_pkg::*;
#(
  parameter int unsigned MAX_COUNT = MAX_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [CNT_W-1:0] in_chosen_count,
  input  wire logic [CNT_W-1:0] in_total_count,
  output logic                  out_valid,
  output logic      [MOD_W-1:0] out_result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [MOD_W-1:0] cfg_modulus
);

  pcmp_state_t state_r, state_nxt;

  logic [MOD_W-1:0] modulus_r;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] d_r, d_nxt;
  logic [CNT_W-1:0] iter_r, iter_nxt;
  logic [MOD_W-1:0] acc_r, acc_nxt;
  logic [MOD_W-1:0] imod_r, imod_nxt;
  logic [MOD_W-1:0] base_r, base_nxt;
  logic [MOD_W-1:0] exp_r, exp_nxt;
  logic [MOD_W-1:0] pw_r, pw_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [MOD_W-1:0] out_result_r, out_result_nxt;

  logic             mul_start;
  logic [MOD_W-1:0] mul_a;
  logic [MOD_W-1:0] mul_b;
  logic             mul_done;
  logic [MOD_W-1:0] mul_p;

  logic [CNT_W-1:0] n_sat;
  logic [CNT_W-1:0] k_sat;
  logic             mod_small;
  logic [MOD_W:0]   imod_inc;

  // Counts saturate at the configured limit.
  assign n_sat = (32'(in_chosen_count) > MAX_COUNT) ? CNT_W'(MAX_COUNT) : in_chosen_count;
  assign k_sat = (32'(in_total_count) > MAX_COUNT) ? CNT_W'(MAX_COUNT) : in_total_count;

  // A modulus of zero or one gives a zero result straight away.
  assign mod_small = (modulus_r < MOD_W'(2));

  // Next factor i mod m, kept by wrapping rather than dividing.
  assign imod_inc = {1'b0, imod_r} + 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (mod_small) begin
            state_nxt = ST_IDLE;
          end else if (k_sat == '0) begin
            state_nxt = ST_POW_BIT;
          end else begin
            state_nxt = ST_FACT_GO;
          end
        end
      end
      ST_FACT_GO:   state_nxt = ST_FACT_WAIT;
      ST_FACT_WAIT: begin
        if (mul_done) begin
          state_nxt = (iter_r == k_r) ? ST_POW_BIT : ST_FACT_GO;
        end
      end
      ST_POW_BIT: begin
        if (exp_r == '0) begin
          state_nxt = ST_FIN_GO;
        end else if (exp_r[0]) begin
          state_nxt = ST_PMUL_GO;
        end else begin
          state_nxt = ST_SQR_GO;
        end
      end
      ST_PMUL_GO:   state_nxt = ST_PMUL_WAIT;
      ST_PMUL_WAIT: if (mul_done) state_nxt = ST_SQR_GO;
      ST_SQR_GO:    state_nxt = ST_SQR_WAIT;
      ST_SQR_WAIT:  if (mul_done) state_nxt = ST_POW_BIT;
      ST_FIN_GO:    state_nxt = ST_FIN_WAIT;
      ST_FIN_WAIT:  if (mul_done) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier issue and operand selection.
  always_comb begin
    mul_start = state_r inside {ST_FACT_GO, ST_PMUL_GO, ST_SQR_GO, ST_FIN_GO};
    case (state_r)
      ST_FACT_GO: begin
        mul_a = acc_r;
        mul_b = imod_r;
      end
      ST_PMUL_GO: begin
        mul_a = pw_r;
        mul_b = base_r;
      end
      ST_SQR_GO: begin
        mul_a = base_r;
        mul_b = base_r;
      end
      ST_FIN_GO: begin
        mul_a = acc_r;
        mul_b = pw_r;
      end
      default: begin
        mul_a = acc_r;
        mul_b = pw_r;
      end
    endcase
  end

  // Datapath registers: factorial run, power run and result strobe.
  always_comb begin
    k_nxt          = k_r;
    d_nxt          = d_r;
    iter_nxt       = iter_r;
    acc_nxt        = acc_r;
    imod_nxt       = imod_r;
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    pw_nxt         = pw_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // The denominator is (k-n)!, or 1 when n exceeds k.
          k_nxt    = k_sat;
          d_nxt    = (n_sat <= k_sat) ? (k_sat - n_sat) : '0;
          iter_nxt = CNT_W'(1);
          acc_nxt  = MOD_W'(1);
          imod_nxt = MOD_W'(1);
          base_nxt = MOD_W'(1);
          pw_nxt   = MOD_W'(1);
          exp_nxt  = modulus_r - MOD_W'(2);
          if (mod_small) begin
            out_valid_nxt  = 1'b1;
            out_result_nxt = '0;
          end
        end
      end
      ST_FACT_WAIT: begin
        if (mul_done) begin
          acc_nxt  = mul_p;
          // Keep the partial factorial once it reaches the denominator.
          if (iter_r == d_r) begin
            base_nxt = mul_p;
          end
          iter_nxt = iter_r + 1'b1;
          imod_nxt = (imod_inc == {1'b0, modulus_r}) ? '0 : imod_inc[MOD_W-1:0];
        end
      end
      ST_PMUL_WAIT: begin
        if (mul_done) begin
          pw_nxt = mul_p;
        end
      end
      ST_SQR_WAIT: begin
        if (mul_done) begin
          base_nxt = mul_p;
          exp_nxt  = {1'b0, exp_r[MOD_W-1:1]};
        end
      end
      ST_FIN_WAIT: begin
        if (mul_done) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = mul_p;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        modulus_r <= cfg_modulus;
      end
    end
    k_r          <= k_nxt;
    d_r          <= d_nxt;
    iter_r       <= iter_nxt;
    acc_r        <= acc_nxt;
    imod_r       <= imod_nxt;
    base_r       <= base_nxt;
    exp_r        <= exp_nxt;
    pw_r         <= pw_nxt;
    out_result_r <= out_result_nxt;
  end

  pcmp_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (modulus_r),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

>>> rtl/pcmp_checker.sv
// ----------------------------------------------------------------------------
// pcmp_checker
// Port-level checks of the permutation count block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "permutation_count_mod_prime_assert.svh"

module pcmp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic cfg_ready
);

  // An accepted request is either at work or already answered.
  `PCMP_ASSERT_NEXT(a_req_taken, start && !busy, busy || out_valid)

  // Finishing a request always delivers its result.
  `PCMP_ASSERT_SAME(a_fin_result, $fell(busy), out_valid)

  // A result is only shown once the block has gone idle.
  `PCMP_ASSERT_SAME(a_result_idle, out_valid, !busy)

  // The modulus cannot be written while a request is at work.
  `PCMP_ASSERT_SAME(a_cfg_closed, busy, !cfg_ready)

endmodule

bind permutation_count_mod_prime pcmp_checker u_pcmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

>>> dv/permutation_count_mod_prime_tb.sv
// ----------------------------------------------------------------------------
// permutation_count_mod_prime_tb
// Checks the k! / (k-n)! modulo m engine against a behavioural predictor. The
// run steps through several moduli (the reset value, values below three,
// small and large primes, composites and the extremes). Each phase sends
// random requests, in most phases after directed counts, in bursts with
// random gaps. Every result is compared in order with its prediction.
// ----------------------------------------------------------------------------
module permutation_count_mod_prime_tb;
  import pcmp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [CNT_W-1:0] chosen;
    logic [CNT_W-1:0] total;
  } count_pair_t;

  // One step of the run: either a modulus write or a request to send.
  typedef struct {
    bit               set_modulus;
    logic [MOD_W-1:0] modulus;
    count_pair_t      counts;
  } run_step_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [CNT_W-1:0] in_chosen_count = '0;
  logic [CNT_W-1:0] in_total_count = '0;
  logic             out_valid;
  logic [MOD_W-1:0] out_result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [MOD_W-1:0] cfg_modulus = '0;

  run_step_t        run_plan[$];
  count_pair_t      count_requests[$];
  logic [MOD_W-1:0] npr_expected[$];
  logic [MOD_W-1:0] modulus_now = MOD_RESET;
  longint unsigned  cycle_budget = 0;
  longint unsigned  cycle_limit = 64'd100_000_000;
  longint unsigned  cycle_count = 0;
  int               errors = 0;
  int               burst_left = 1;
  int               gap_left = 0;
  int               gap_roll;

  permutation_count_mod_prime dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_chosen_count (in_chosen_count),
    .in_total_count  (in_total_count),
    .out_valid       (out_valid),
    .out_result      (out_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_modulus     (cfg_modulus)
  );

  always #1 clk = ~clk;

  // Running product 1 * 2 * ... * upto, reduced modulo m at every step.
  function automatic longint unsigned factorial_mod(input longint unsigned upto,
                                                    input longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    for (longint unsigned i = 1; i <= upto; i++) begin
      acc = (acc * (i % m)) % m;
    end
    return acc;
  endfunction

  // Predicted result: k! times the Fermat power of (k-n)!, all modulo m.
  function automatic logic [MOD_W-1:0] npr_mod(input logic [CNT_W-1:0] chosen,
                                               input logic [CNT_W-1:0] total,
                                               input logic [MOD_W-1:0] modulus);
    longint unsigned m, num, den, acc, base, e;
    m = modulus;
    if (m < 2) begin
      return '0;
    end
    num = factorial_mod(total, m);
    // A chosen count above the total leaves the denominator at one.
    den = (chosen <= total) ? factorial_mod(total - chosen, m) : 1 % m;
    acc = 1 % m;
    base = den % m;
    e = m - 2;
    while (e != 0) begin
      if ((e & 1) != 0) begin
        acc = (acc * base) % m;
      end
      base = (base * base) % m;
      e = e >> 1;
    end
    return MOD_W'((num * acc) % m);
  endfunction

  function automatic void add_request(input int chosen, input int total);
    run_step_t s;
    s.set_modulus = 1'b0;
    s.modulus = '0;
    s.counts.chosen = CNT_W'(chosen);
    s.counts.total = CNT_W'(total);
    run_plan.push_back(s);
    // Worst case latency plus the longest sender gap.
    cycle_budget += 32 * (longint'(total) + 64) + 300;
  endfunction

  function automatic void add_modulus(input logic [MOD_W-1:0] m);
    run_step_t s;
    s.set_modulus = 1'b1;
    s.modulus = m;
    s.counts.chosen = '0;
    s.counts.total = '0;
    run_plan.push_back(s);
    cycle_budget += 200;
  endfunction

  // Mostly small well-formed counts, some with the chosen count above the total.
  function automatic void add_random_requests(input int count);
    int total, chosen;
    for (int i = 0; i < count; i++) begin
      total = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 40) : $urandom_range(41, 300);
      chosen = ($urandom_range(0, 9) < 7) ? $urandom_range(0, total) : $urandom_range(0, 65535);
      add_request(chosen, total);
    end
  endfunction

  // Request driver: holds each request until accepted, with bursts and gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        npr_expected.push_back(npr_mod(in_chosen_count, in_total_count, modulus_now));
        void'(count_requests.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 6);
          gap_roll = $urandom_range(0, 9);
          gap_left = (gap_roll < 4) ? 0 :
                     (gap_roll < 8) ? $urandom_range(1, 8) : $urandom_range(9, 200);
        end
      end
      if (start && busy) begin
        // The current request stays on the ports until the block takes it.
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (count_requests.size() != 0) begin
        start <= 1'b1;
        in_chosen_count <= count_requests[0].chosen;
        in_total_count <= count_requests[0].total;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: every strobed result must match the oldest prediction.
  always @(posedge clk) begin : result_check
    logic [MOD_W-1:0] want;
    if (rst_n && out_valid) begin
      if (npr_expected.size() == 0) begin
        $error("out_result: no result expected, actual %0d", out_result);
        errors++;
      end else begin
        want = npr_expected.pop_front();
        if (out_result !== want) begin
          $error("out_result: expected %0d, actual %0d", want, out_result);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    // Reset modulus: boundaries, chosen above total, and one full-width total.
    add_request(0, 0);
    add_request(0, 1);
    add_request(1, 1);
    add_request(5, 5);
    add_request(3, 5);
    add_request(6, 5);
    add_request(65535, 0);
    add_request(0, 12);
    add_request(12, 12);
    add_request(16'hAAAA, 65535);
    add_random_requests(10);
    // Moduli zero and one always answer zero.
    add_modulus(30'd0);
    add_request(3, 5);
    add_random_requests(3);
    add_modulus(30'd1);
    add_request(2, 7);
    add_random_requests(3);
    // Modulus two: the Fermat exponent is zero.
    add_modulus(30'd2);
    add_request(0, 1);
    add_request(1, 3);
    add_request(2, 2);
    add_random_requests(3);
    add_modulus(30'd3);
    add_request(0, 2);
    add_request(1, 2);
    add_request(0, 3);
    add_request(1, 5);
    add_random_requests(5);
    // Small prime: a denominator that the modulus divides.
    add_modulus(30'd7);
    add_request(2, 20);
    add_request(9, 8);
    add_request(3, 6);
    add_random_requests(6);
    // Composite moduli, the all-ones one among them.
    add_modulus(30'd15);
    add_request(2, 5);
    add_request(1, 4);
    add_random_requests(5);
    add_modulus(30'h3FFF_FFFF);
    add_request(4, 9);
    add_random_requests(6);
    add_modulus(30'd1073741789);
    add_random_requests(8);
    add_modulus(30'd65537);
    add_random_requests(8);
    add_modulus(MOD_W'($urandom_range(3, 32'h3FFF_FFFF)));
    add_random_requests(6);
    add_modulus(MOD_RESET);
    add_random_requests(20);
    cycle_limit = 3 * cycle_budget + 20000;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (run_plan[i]) begin
      if (run_plan[i].set_modulus) begin
        // Write the modulus only once the block has drained.
        while (count_requests.size() != 0 || npr_expected.size() != 0 || busy) begin
          @(posedge clk);
        end
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_modulus <= run_plan[i].modulus;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        modulus_now = run_plan[i].modulus;
      end else begin
        count_requests.push_back(run_plan[i].counts);
      end
    end

    while (count_requests.size() != 0 || npr_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
